// ===== src/pba_pkg.sv =====
// Shared types and constants for the page bitmap allocator.
// No dependencies; used by pba_row_unit and page_bitmap_allocator_top.
package pba_pkg;

  localparam int unsigned MAX_PAGES_DEF       = 4096;
  localparam int unsigned PAGE_BYTES_LOG2_DEF = 12;

  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned BIT_W     = 5;
  localparam int unsigned POP_W     = 6;
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned LIMIT_W   = 13;
  localparam int unsigned FREE_W    = 13;

  localparam logic [FREE_W-1:0]  COUNT_MAX = 13'h1FFF;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 13'd4096;

  typedef enum logic [1:0] {
    MODE_ALLOC      = 2'd0,
    MODE_FREE       = 2'd1,
    MODE_RANGE_FREE = 2'd2,
    MODE_RANGE_USED = 2'd3
  } pba_mode_e;

  typedef enum logic [1:0] {
    SK_COUNT = 2'd0,
    SK_ALLOC = 2'd1,
    SK_FREE  = 2'd2,
    SK_USE   = 2'd3
  } pba_scan_e;

  typedef struct packed {
    pba_scan_e        kind;
    logic [BIT_W-1:0] lo;
    logic [BIT_W-1:0] hi;
  } pba_row_ctrl_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] data;
    logic                 wr;
    logic                 hit;
    logic [BIT_W-1:0]     hit_bit;
    logic [POP_W-1:0]     pop;
  } pba_row_res_t;

endpackage

// ===== src/page_bitmap_allocator_top.sv =====
// First-fit page frame allocator over a used-bit map held in a word memory.
// Depends on pba_pkg and pba_row_unit.
//
//   port group        | dir | handshake               | payload
//   ------------------+-----+-------------------------+-------------------------------------
//   request           | in  | in_valid_i/in_ready_o   | mode_i, address_i, end_address_i
//   result            | out | out_valid_o/out_ready_i | done_ok_o, page_address_o, free_count_o
//   page limit write  | in  | cfg_valid_i/cfg_ready_o | page_limit_i
//
// After reset a fill pass sets the map to all used, one word a cycle, before the first
// request is taken. Allocate scans the map from word 0 up to the first free page.
// Free page and range requests pass through the prepare steps, then, if inside the page
// limit, scan each map word they touch. The first request after a page limit write first
// recounts the free pages below the new limit. The memory read port reads one word a
// cycle; a held result stalls the finish of the next request only, not its acceptance.
module page_bitmap_allocator_top #(
  parameter int unsigned MAX_PAGES       = pba_pkg::MAX_PAGES_DEF,
  parameter int unsigned PAGE_BYTES_LOG2 = pba_pkg::PAGE_BYTES_LOG2_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    mode_i,
  input  logic [pba_pkg::ADDR_W-1:0]    address_i,
  input  logic [pba_pkg::ADDR_W-1:0]    end_address_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          done_ok_o,
  output logic [pba_pkg::ADDR_W-1:0]    page_address_o,
  output logic [pba_pkg::FREE_W-1:0]    free_count_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pba_pkg::LIMIT_W-1:0]   page_limit_i
);

  localparam int unsigned W      = pba_pkg::WORD_BITS;
  localparam int unsigned BW     = pba_pkg::BIT_W;
  localparam int unsigned AW     = pba_pkg::ADDR_W;
  localparam int unsigned FW     = pba_pkg::FREE_W;
  localparam int unsigned ROWS   = (MAX_PAGES + W - 1) / W;
  localparam int unsigned ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned PIX_W  = ROW_W + BW;
  localparam int unsigned LIM_W  = $clog2(MAX_PAGES + 1);
  localparam int unsigned CNT_W  = LIM_W;
  localparam int unsigned PN_W   = 34 - PAGE_BYTES_LOG2;
  localparam int unsigned LIM_RST = (MAX_PAGES < 32'(pba_pkg::LIMIT_RST)) ?
                                    MAX_PAGES : 32'(pba_pkg::LIMIT_RST);
  localparam logic [AW:0] PAGE_ROUND = (AW + 1)'((64'd1 << PAGE_BYTES_LOG2) - 64'd1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREP1,
    ST_PREP2,
    ST_PREP3,
    ST_LAUNCH,
    ST_SCAN,
    ST_FIN
  } state_e;

  state_e                state_q;
  logic [ROW_W-1:0]      clr_row_q;
  logic [LIM_W-1:0]      lim_q;
  logic                  dirty_q;
  logic [CNT_W-1:0]      cnt_q;
  pba_pkg::pba_mode_e    mode_q;
  logic [PN_W-1:0]       rfirst_q;
  logic [PN_W-1:0]       rlast_q;
  logic [AW-1:0]         rdiff_q;
  logic                  rempty_q;
  logic                  rok_q;
  pba_pkg::pba_scan_e    kind_q;
  logic [PIX_W-1:0]      scan_first_q;
  logic [PIX_W-1:0]      scan_last_q;
  logic [ROW_W-1:0]      rd_row_q;
  logic                  issue_q;
  logic                  ev_vld_q;
  logic [ROW_W-1:0]      ev_row_q;
  logic                  ok_q;
  logic [AW-1:0]         paddr_q;
  logic                  out_valid_q;
  logic                  out_ok_q;
  logic [AW-1:0]         out_addr_q;
  logic [FW-1:0]         out_free_q;

  logic [W-1:0]          bitmap_mem [ROWS];
  logic [W-1:0]          rd_data_q;

  logic                  mem_we;
  logic [ROW_W-1:0]      mem_wa;
  logic [W-1:0]          mem_wd;
  logic                  mem_re;

  logic [ROW_W-1:0]      first_row;
  logic [ROW_W-1:0]      last_row;
  logic [PIX_W-1:0]      lim_last_pix;
  logic                  scan_done;
  logic [FW-1:0]         free_sat;

  pba_pkg::pba_row_ctrl_t row_ctrl;
  pba_pkg::pba_row_res_t  row_res;

  assign first_row    = scan_first_q[PIX_W-1:BW];
  assign last_row     = scan_last_q[PIX_W-1:BW];
  assign lim_last_pix = PIX_W'(lim_q - LIM_W'(1));

  assign row_ctrl.kind = kind_q;
  assign row_ctrl.lo   = (ev_row_q == first_row) ? scan_first_q[BW-1:0] : '0;
  assign row_ctrl.hi   = (ev_row_q == last_row) ? scan_last_q[BW-1:0] : '1;

  pba_row_unit u_row (
    .data_i (rd_data_q),
    .ctrl_i (row_ctrl),
    .res_o  (row_res)
  );

  assign scan_done = ev_vld_q &&
                     ((ev_row_q == last_row) || ((kind_q == pba_pkg::SK_ALLOC) && row_res.hit));

  assign free_sat = (32'(cnt_q) > 32'(pba_pkg::COUNT_MAX)) ? pba_pkg::COUNT_MAX : FW'(cnt_q);

  assign mem_we = (state_q == ST_CLEAR) || ((state_q == ST_SCAN) && ev_vld_q && row_res.wr);
  assign mem_wa = (state_q == ST_CLEAR) ? clr_row_q : ev_row_q;
  assign mem_wd = (state_q == ST_CLEAR) ? '1 : row_res.data;
  assign mem_re = (state_q == ST_SCAN) && issue_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      bitmap_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_q <= bitmap_mem[rd_row_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_row_q    <= '0;
      lim_q        <= LIM_W'(LIM_RST);
      dirty_q      <= 1'b0;
      cnt_q        <= '0;
      mode_q       <= pba_pkg::MODE_ALLOC;
      rfirst_q     <= '0;
      rlast_q      <= '0;
      rdiff_q      <= '0;
      rempty_q     <= 1'b0;
      rok_q        <= 1'b0;
      kind_q       <= pba_pkg::SK_COUNT;
      scan_first_q <= '0;
      scan_last_q  <= '0;
      rd_row_q     <= '0;
      issue_q      <= 1'b0;
      ev_vld_q     <= 1'b0;
      ev_row_q     <= '0;
      ok_q         <= 1'b0;
      paddr_q      <= '0;
      out_valid_q  <= 1'b0;
      out_ok_q     <= 1'b0;
      out_addr_q   <= '0;
      out_free_q   <= '0;
    end else begin
      if (cfg_valid_i) begin
        lim_q   <= (32'(page_limit_i) > 32'(MAX_PAGES)) ? LIM_W'(MAX_PAGES)
                                                         : LIM_W'(page_limit_i);
        dirty_q <= 1'b1;
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_row_q <= clr_row_q + ROW_W'(1);
          if (clr_row_q == ROW_W'(ROWS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            mode_q   <= pba_pkg::pba_mode_e'(mode_i);
            rfirst_q <= PN_W'(address_i >> PAGE_BYTES_LOG2);
            rdiff_q  <= end_address_i - address_i;
            rempty_q <= (mode_i != pba_pkg::MODE_FREE) && (end_address_i <= address_i);
            ok_q     <= 1'b0;
            paddr_q  <= '0;
            state_q  <= (mode_i == pba_pkg::MODE_ALLOC) ? ST_LAUNCH : ST_PREP1;
          end
        end
        ST_PREP1: begin
          rlast_q <= (mode_q == pba_pkg::MODE_FREE) ? PN_W'(1) :
                     PN_W'(((AW + 1)'(rdiff_q) + PAGE_ROUND) >> PAGE_BYTES_LOG2);
          state_q <= ST_PREP2;
        end
        ST_PREP2: begin
          rlast_q <= rfirst_q + rlast_q - PN_W'(1);
          rok_q   <= !rempty_q && (64'(rfirst_q) < 64'(lim_q));
          state_q <= ST_PREP3;
        end
        ST_PREP3: begin
          if (64'(rlast_q) >= 64'(lim_q)) begin
            rlast_q <= PN_W'(lim_q - LIM_W'(1));
          end
          state_q <= ST_LAUNCH;
        end
        ST_LAUNCH: begin
          if (dirty_q) begin
            cnt_q <= '0;
            if (lim_q == '0) begin
              dirty_q <= 1'b0;
            end else begin
              kind_q       <= pba_pkg::SK_COUNT;
              scan_first_q <= '0;
              scan_last_q  <= lim_last_pix;
              rd_row_q     <= '0;
              issue_q      <= 1'b1;
              ev_vld_q     <= 1'b0;
              state_q      <= ST_SCAN;
            end
          end else if (mode_q == pba_pkg::MODE_ALLOC) begin
            if (lim_q == '0) begin
              state_q <= ST_FIN;
            end else begin
              kind_q       <= pba_pkg::SK_ALLOC;
              scan_first_q <= '0;
              scan_last_q  <= lim_last_pix;
              rd_row_q     <= '0;
              issue_q      <= 1'b1;
              ev_vld_q     <= 1'b0;
              state_q      <= ST_SCAN;
            end
          end else if (rok_q) begin
            kind_q       <= (mode_q == pba_pkg::MODE_RANGE_USED) ? pba_pkg::SK_USE
                                                                 : pba_pkg::SK_FREE;
            scan_first_q <= PIX_W'(rfirst_q);
            scan_last_q  <= PIX_W'(rlast_q);
            rd_row_q     <= ROW_W'(PIX_W'(rfirst_q) >> BW);
            issue_q      <= 1'b1;
            ev_vld_q     <= 1'b0;
            state_q      <= ST_SCAN;
          end else begin
            state_q <= ST_FIN;
          end
        end
        ST_SCAN: begin
          if (issue_q) begin
            ev_vld_q <= 1'b1;
            ev_row_q <= rd_row_q;
            if (rd_row_q == last_row) begin
              issue_q <= 1'b0;
            end else begin
              rd_row_q <= rd_row_q + ROW_W'(1);
            end
          end else begin
            ev_vld_q <= 1'b0;
          end
          if (ev_vld_q) begin
            case (kind_q)
              pba_pkg::SK_COUNT, pba_pkg::SK_FREE: begin
                cnt_q <= cnt_q + CNT_W'(row_res.pop);
              end
              pba_pkg::SK_USE: begin
                cnt_q <= cnt_q - CNT_W'(row_res.pop);
              end
              pba_pkg::SK_ALLOC: begin
                if (row_res.hit) begin
                  cnt_q   <= cnt_q - CNT_W'(1);
                  ok_q    <= 1'b1;
                  paddr_q <= AW'(64'({ev_row_q, row_res.hit_bit}) << PAGE_BYTES_LOG2);
                end
              end
              default: begin
              end
            endcase
          end
          if (scan_done) begin
            issue_q  <= 1'b0;
            ev_vld_q <= 1'b0;
            if (kind_q == pba_pkg::SK_COUNT) begin
              dirty_q <= 1'b0;
              state_q <= ST_LAUNCH;
            end else begin
              if (kind_q != pba_pkg::SK_ALLOC) begin
                ok_q <= 1'b1;
              end
              state_q <= ST_FIN;
            end
          end
        end
        ST_FIN: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_ok_q    <= ok_q;
            out_addr_q  <= paddr_q;
            out_free_q  <= free_sat;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o     = (state_q == ST_IDLE);
  assign cfg_ready_o    = 1'b1;
  assign out_valid_o    = out_valid_q;
  assign done_ok_o      = out_ok_q;
  assign page_address_o = out_addr_q;
  assign free_count_o   = out_free_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && !dirty_q) |-> (32'(cnt_q) <= 32'(lim_q)))
    else $error("free count exceeds page limit");

  a_rd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && issue_q) |-> (rd_row_q <= last_row))
    else $error("map read past last word of scan");

  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_FIN))
    else $error("result raised outside finish step");

  a_alloc_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && ev_vld_q && kind_q == pba_pkg::SK_ALLOC && row_res.hit)
      |-> (mem_we && (row_res.data != rd_data_q)))
    else $error("allocation hit without map update");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q != ST_IDLE && !in_ready_o))
    else $error("request taken while still idle");

endmodule

// ===== src/pba_row_unit.sv =====
// Shared row unit: masks one bitmap word, finds the lowest free bit,
// counts bits and forms the updated word. Depends on pba_pkg.
module pba_row_unit (
  input  logic [pba_pkg::WORD_BITS-1:0] data_i,
  input  pba_pkg::pba_row_ctrl_t        ctrl_i,
  output pba_pkg::pba_row_res_t         res_o
);

  localparam int unsigned W  = pba_pkg::WORD_BITS;
  localparam int unsigned BW = pba_pkg::BIT_W;
  localparam int unsigned PW = pba_pkg::POP_W;

  logic [W-1:0]  mask;
  logic [W-1:0]  free_bits;
  logic [W-1:0]  used_bits;
  logic [W-1:0]  pop_src;
  logic [W-1:0]  low_bit;
  logic [PW-1:0] pop;
  logic [BW-1:0] hit_bit;

  always_comb begin
    mask      = ({W{1'b1}} << ctrl_i.lo) & ({W{1'b1}} >> (BW'(W - 1) - ctrl_i.hi));
    free_bits = ~data_i & mask;
    used_bits = data_i & mask;
    pop_src   = (ctrl_i.kind == pba_pkg::SK_FREE) ? used_bits : free_bits;
    low_bit   = free_bits & (~free_bits + W'(1));
    pop       = '0;
    hit_bit   = '0;
    for (int i = 0; i < W; i++) begin
      pop = pop + PW'(pop_src[i]);
      if (low_bit[i]) begin
        hit_bit = BW'(i);
      end
    end
    res_o.hit     = |free_bits;
    res_o.hit_bit = hit_bit;
    res_o.pop     = pop;
    case (ctrl_i.kind)
      pba_pkg::SK_ALLOC: begin
        res_o.data = data_i | low_bit;
        res_o.wr   = |free_bits;
      end
      pba_pkg::SK_FREE: begin
        res_o.data = data_i & ~mask;
        res_o.wr   = 1'b1;
      end
      pba_pkg::SK_USE: begin
        res_o.data = data_i | mask;
        res_o.wr   = 1'b1;
      end
      default: begin
        res_o.data = data_i;
        res_o.wr   = 1'b0;
      end
    endcase
  end

endmodule

// ===== tb/page_bitmap_allocator_top_tb.sv =====
// Testbench for page_bitmap_allocator_top: directed and random requests against a
// bit-accurate predictor of the used-page map, with random idling and back-pressure.
// Depends on pba_pkg and the allocator RTL only.
module page_bitmap_allocator_top_tb;

  localparam int unsigned PAGES          = pba_pkg::MAX_PAGES_DEF;
  localparam int unsigned PAGE_SHIFT     = pba_pkg::PAGE_BYTES_LOG2_DEF;
  localparam int unsigned ADDR_W         = pba_pkg::ADDR_W;
  localparam int unsigned FREE_W         = pba_pkg::FREE_W;
  localparam int unsigned LIMIT_W        = pba_pkg::LIMIT_W;
  localparam longint unsigned PAGE_MASK  = (64'd1 << PAGE_SHIFT) - 1;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned DEFAULT_IDLE   = 21;

  typedef struct {
    logic              done_ok;
    logic [ADDR_W-1:0] page_address;
    logic [FREE_W-1:0] free_count;
  } page_result_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               in_valid_i    = 1'b0;
  logic               in_ready_o;
  logic [1:0]         mode_i        = pba_pkg::MODE_ALLOC;
  logic [ADDR_W-1:0]  address_i     = '0;
  logic [ADDR_W-1:0]  end_address_i = '0;
  logic               out_valid_o;
  logic               out_ready_i   = 1'b0;
  logic               done_ok_o;
  logic [ADDR_W-1:0]  page_address_o;
  logic [FREE_W-1:0]  free_count_o;
  logic               cfg_valid_i   = 1'b0;
  logic               cfg_ready_o;
  logic [LIMIT_W-1:0] page_limit_i  = pba_pkg::LIMIT_RST;

  bit                 page_used [PAGES];
  logic [LIMIT_W-1:0] page_limit_q = pba_pkg::LIMIT_RST;
  page_result_t       pending_results [$];
  page_result_t       oldest_result;
  int unsigned        mismatches    = 0;
  int unsigned        tx_idle_pct   = DEFAULT_IDLE;
  int unsigned        rx_idle_pct   = DEFAULT_IDLE;
  int unsigned        rx_stall_left = 0;
  int unsigned        quiet_cycles  = 0;

  wire in_fire  = in_valid_i & in_ready_o;
  wire out_fire = out_valid_o & out_ready_i;
  wire cfg_fire = cfg_valid_i & cfg_ready_o;

  page_bitmap_allocator_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .address_i      (address_i),
    .end_address_i  (end_address_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .done_ok_o      (done_ok_o),
    .page_address_o (page_address_o),
    .free_count_o   (free_count_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .page_limit_i   (page_limit_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    for (int unsigned i = 0; i < PAGES; i++) page_used[i] = 1'b1;
  end

  function automatic page_result_t predict_request(input pba_pkg::pba_mode_e m,
                                                   input logic [ADDR_W-1:0] a,
                                                   input logic [ADDR_W-1:0] e);
    page_result_t    r;
    longint unsigned lim, pg, pg_first, pg_last, span, la, le;
    int unsigned     n;
    bit              found;
    lim            = (page_limit_q < PAGES) ? page_limit_q : PAGES;
    la             = a;
    le             = e;
    found          = 1'b0;
    r.done_ok      = 1'b0;
    r.page_address = '0;
    case (m)
      pba_pkg::MODE_ALLOC: begin
        for (pg = 0; pg < lim; pg++) begin
          if (!found && !page_used[pg]) begin
            page_used[pg]  = 1'b1;
            found          = 1'b1;
            r.done_ok      = 1'b1;
            r.page_address = ADDR_W'(pg << PAGE_SHIFT);
          end
        end
      end
      pba_pkg::MODE_FREE: begin
        pg = la >> PAGE_SHIFT;
        if (pg < lim) begin
          page_used[pg] = 1'b0;
          r.done_ok     = 1'b1;
        end
      end
      default: begin
        if (le > la && lim != 0) begin
          pg_first = la >> PAGE_SHIFT;
          span     = (le - la + PAGE_MASK) >> PAGE_SHIFT;
          pg_last  = pg_first + span - 1;
          if (pg_last >= lim) pg_last = lim - 1;
          for (pg = pg_first; pg <= pg_last; pg++) begin
            page_used[pg] = (m == pba_pkg::MODE_RANGE_USED);
            r.done_ok     = 1'b1;
          end
        end
      end
    endcase
    n = 0;
    for (pg = 0; pg < lim; pg++) if (!page_used[pg]) n++;
    r.free_count = (n > pba_pkg::COUNT_MAX) ? pba_pkg::COUNT_MAX : n[FREE_W-1:0];
    return r;
  endfunction

  task automatic send_request(input pba_pkg::pba_mode_e m, input logic [ADDR_W-1:0] a,
                              input logic [ADDR_W-1:0] e);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    mode_i        <= m;
    address_i     <= a;
    end_address_i <= e;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(predict_request(m, a, e));
  endtask

  // Hold the request side until every outstanding word has returned.
  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic write_page_limit(input logic [LIMIT_W-1:0] v);
    wait_results_drained();
    cfg_valid_i  <= 1'b1;
    page_limit_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i  <= 1'b0;
    page_limit_q  = v;
  endtask

  function automatic logic [ADDR_W-1:0] random_address();
    int unsigned lim;
    lim = (page_limit_q < PAGES) ? page_limit_q : PAGES;
    if ($urandom_range(9) == 0) return $urandom;
    return (ADDR_W'($urandom_range(lim + 2)) << PAGE_SHIFT) | $urandom_range(PAGE_MASK);
  endfunction

  function automatic logic [ADDR_W-1:0] random_end(input logic [ADDR_W-1:0] a);
    logic [ADDR_W:0] sum;
    case ($urandom_range(9))
      0: return a;
      1: return $urandom;
      2: return '1;
      3: sum = {1'b0, a} + $urandom_range(1, 1 << 22);
      default: sum = {1'b0, a} + $urandom_range(1, 6 << PAGE_SHIFT);
    endcase
    return sum[ADDR_W] ? '1 : sum[ADDR_W-1:0];
  endfunction

  task automatic send_random_request();
    int unsigned       pick;
    logic [ADDR_W-1:0] a;
    pick = $urandom_range(99);
    a    = random_address();
    if (pick < 35)      send_request(pba_pkg::MODE_ALLOC, $urandom, $urandom);
    else if (pick < 60) send_request(pba_pkg::MODE_FREE, a, $urandom);
    else if (pick < 80) send_request(pba_pkg::MODE_RANGE_FREE, a, random_end(a));
    else                send_request(pba_pkg::MODE_RANGE_USED, a, random_end(a));
  endtask

  task automatic test_directed();
    send_request(pba_pkg::MODE_ALLOC, '0, '0);
    send_request(pba_pkg::MODE_RANGE_FREE, 32'h0000_0000, 32'h0001_0000);
    send_request(pba_pkg::MODE_ALLOC, '1, '1);
    send_request(pba_pkg::MODE_ALLOC, '0, '0);
    send_request(pba_pkg::MODE_FREE, 32'h0000_1234, '0);
    send_request(pba_pkg::MODE_ALLOC, '0, '0);
    send_request(pba_pkg::MODE_FREE, 32'hFFFF_FFFF, '0);
    send_request(pba_pkg::MODE_FREE, 32'h00FF_FFFF, '1);
    send_request(pba_pkg::MODE_RANGE_USED, 32'h0000_8000, 32'h0000_8000);
    send_request(pba_pkg::MODE_RANGE_FREE, 32'h0000_9000, 32'h0000_2000);
    send_request(pba_pkg::MODE_RANGE_USED, 32'h0000_5FFF, 32'h0000_6001);
    send_request(pba_pkg::MODE_RANGE_FREE, 32'hFFFF_F000, 32'hFFFF_FFFF);
    send_request(pba_pkg::MODE_RANGE_FREE, 32'h00FF_F000, 32'hFFFF_FFFF);
    send_request(pba_pkg::MODE_ALLOC, '0, '0);
    send_request(pba_pkg::MODE_RANGE_FREE, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(pba_pkg::MODE_ALLOC, '0, '0);
    send_request(pba_pkg::MODE_RANGE_USED, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(pba_pkg::MODE_ALLOC, '0, '0);
    send_request(pba_pkg::MODE_RANGE_FREE, 32'h0000_0FFF, 32'h0000_1001);
    send_request(pba_pkg::MODE_ALLOC, '0, '0);
  endtask

  task automatic test_limit_extremes();
    write_page_limit(13'd0);
    send_request(pba_pkg::MODE_RANGE_FREE, 32'h0000_0000, 32'h0001_0000);
    send_request(pba_pkg::MODE_ALLOC, '0, '0);
    send_request(pba_pkg::MODE_FREE, 32'h0000_0000, '0);
    write_page_limit(13'd1);
    send_request(pba_pkg::MODE_RANGE_FREE, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(pba_pkg::MODE_ALLOC, '0, '0);
    write_page_limit(13'd8191);
    send_request(pba_pkg::MODE_RANGE_FREE, 32'h0000_0000, 32'h0010_0000);
    send_request(pba_pkg::MODE_FREE, 32'h00FF_F000, '0);
    write_page_limit(13'd33);
    send_request(pba_pkg::MODE_FREE, 32'h0002_8000, '0);
    send_request(pba_pkg::MODE_ALLOC, '0, '0);
    write_page_limit(13'd32);
    send_request(pba_pkg::MODE_RANGE_USED, 32'h0000_0000, 32'h0002_0000);
    send_request(pba_pkg::MODE_ALLOC, '0, '0);
    write_page_limit(13'd31);
    send_request(pba_pkg::MODE_FREE, 32'h0001_F000, '0);
    write_page_limit(13'd4095);
    send_request(pba_pkg::MODE_ALLOC, '0, '0);
    write_page_limit(pba_pkg::LIMIT_RST);
    send_request(pba_pkg::MODE_FREE, 32'h00FF_F123, '0);
    send_request(pba_pkg::MODE_ALLOC, '0, '0);
  endtask

  task automatic test_random_phases();
    for (int unsigned phase = 0; phase < 7; phase++) begin
      case (phase)
        0: write_page_limit(pba_pkg::LIMIT_RST);
        1: write_page_limit(13'd96);
        2: write_page_limit(LIMIT_W'($urandom_range(8191)));
        3: write_page_limit(13'd4095);
        4: write_page_limit(13'd1000);
        5: write_page_limit(LIMIT_W'($urandom_range(4096)));
        default: write_page_limit(pba_pkg::LIMIT_RST);
      endcase
      repeat (200) send_random_request();
    end
  endtask

  task automatic test_no_idle();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (300) send_random_request();
    tx_idle_pct = DEFAULT_IDLE;
    rx_idle_pct = DEFAULT_IDLE;
  endtask

  task automatic test_back_pressure();
    tx_idle_pct   = 0;
    rx_stall_left = 400;
    repeat (50) send_random_request();
    tx_idle_pct   = DEFAULT_IDLE;
  endtask

  task automatic test_drain_pause();
    repeat (40) send_random_request();
    wait_results_drained();
    repeat (40) send_random_request();
  endtask

  always @(posedge clk_i) begin
    if (out_fire) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word ok=%0b addr=%h free=%0d", $time,
                 done_ok_o, page_address_o, free_count_o);
        mismatches++;
      end else begin
        oldest_result = pending_results.pop_front();
        if (oldest_result.done_ok !== done_ok_o) begin
          $display("%0t: done_ok expected %0b actual %0b", $time,
                   oldest_result.done_ok, done_ok_o);
          mismatches++;
        end
        if (oldest_result.page_address !== page_address_o) begin
          $display("%0t: page_address expected %h actual %h", $time,
                   oldest_result.page_address, page_address_o);
          mismatches++;
        end
        if (oldest_result.free_count !== free_count_o) begin
          $display("%0t: free_count expected %0d actual %0d", $time,
                   oldest_result.free_count, free_count_o);
          mismatches++;
        end
      end
    end
    if (rx_stall_left != 0) begin
      rx_stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || in_fire || out_fire || cfg_fire) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_limit_extremes();
    test_random_phases();
    test_no_idle();
    test_back_pressure();
    test_drain_pause();
    wait_results_drained();
    repeat (150) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/pba_pkg.sv
src/pba_row_unit.sv
src/page_bitmap_allocator_top.sv
tb/page_bitmap_allocator_top_tb.sv
